// ----- rtl/pbe_pkg.sv -----
// Shared types, fixed-point constants and pipeline latencies for the PBE exchange block.
package pbe_pkg;

  typedef logic signed [63:0] q32_t;

  localparam int FRAC_BITS_DEF = 24;
  localparam int OUT_W         = 48;

  // Q31.32 constants
  localparam q32_t ONE_Q         = 64'sd4294967296;
  localparam q32_t AX_Q          = -64'sd3172085748;
  localparam q32_t UK_Q          = 64'sd3453153706;
  localparam q32_t UM2_Q         = 64'sd1885619258;
  localparam q32_t UL_Q          = 64'sd1172648792;
  localparam q32_t FOUR_THIRDS_Q = 64'sd5726623061;

  localparam int MUL_LAT = 5;
  localparam int RCP_QB  = 33;
  localparam int RCP_LAT = RCP_QB + 1;

endpackage

// ----- rtl/pbe_if.sv -----
// Request channels of the PBE exchange block: grid point in, energy and potential out.
interface pbe_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] density;
  logic        [31:0] grad_ratio;
  logic signed [31:0] grad_curvature;
  logic signed [31:0] laplacian_ratio;

  modport source (output valid, density, grad_ratio, grad_curvature, laplacian_ratio,
                  input ready);
  modport sink   (input valid, density, grad_ratio, grad_curvature, laplacian_ratio,
                  output ready);
endinterface

interface pbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] energy_per_electron;
  logic signed [47:0] potential;

  modport source (output valid, energy_per_electron, potential, input ready);
  modport sink   (input valid, energy_per_electron, potential, output ready);
endinterface

// ----- rtl/pbe_pipe.sv -----
// Enabled delay line used to align operands across the pipeline.
module pbe_pipe #(
  parameter int W     = 64,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// ----- rtl/pbe_mulq.sv -----
// Pipelined Q31.32 signed multiply, round half away from zero, saturating.
module pbe_mulq import pbe_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q32_t a,
  input  q32_t b,
  output q32_t y
);

  localparam logic [127:0] ROUND = 128'h8000_0000;

  logic         neg1_r, neg2_r, neg3_r, neg4_r;
  logic [63:0]  ua_r, ub_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [63:0]  lo_r, hi_r;
  logic [127:0] sum_r;
  q32_t         y_r;

  logic [33:0]  mid;
  logic [63:0]  hi_c;
  logic         sat;
  logic [62:0]  mag;

  always_comb begin
    mid  = 34'(p00_r[63:32]) + 34'(p01_r[31:0]) + 34'(p10_r[31:0]);
    hi_c = p11_r + 64'(p01_r[63:32]) + 64'(p10_r[63:32]) + 64'(mid[33:32]);
    sat  = |sum_r[127:95];
    mag  = sum_r[94:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);
      neg2_r <= neg1_r;
      p00_r  <= ua_r[31:0]  * ub_r[31:0];
      p01_r  <= ua_r[31:0]  * ub_r[63:32];
      p10_r  <= ua_r[63:32] * ub_r[31:0];
      p11_r  <= ua_r[63:32] * ub_r[63:32];
      neg3_r <= neg2_r;
      lo_r   <= {mid[31:0], p00_r[31:0]};
      hi_r   <= hi_c;
      neg4_r <= neg3_r;
      sum_r  <= {hi_r, lo_r} + ROUND;
      if (sat) begin
        y_r <= neg4_r ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else if (neg4_r) begin
        y_r <= -q32_t'({1'b0, mag});
      end else begin
        y_r <= q32_t'({1'b0, mag});
      end
    end
  end

  assign y = y_r;

endmodule

// ----- rtl/pbe_cbrt.sv -----
// Pipelined integer cube root, one 3-bit group of the radicand per stage.
module pbe_cbrt #(
  parameter  int N_W = 56,
  localparam int G   = (N_W + 2) / 3
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] n,
  output logic [G-1:0]   root
);

  localparam int NP = 3 * G;
  localparam int RW = 2 * G + 5;
  localparam int PW = 2 * G + 1;

  logic [G-1:0]  y_r [G];
  logic [RW-1:0] r_r [G];
  logic [NP-1:0] n_r [G];
  logic [NP-1:0] npad;

  assign npad = NP'(n);

  for (genvar k = 0; k < G; k++) begin : g_st
    logic [G-1:0]  y_i;
    logic [RW-1:0] r_i;
    logic [NP-1:0] n_i;
    logic [G-1:0]  y2;
    logic [G:0]    y2p;
    logic [PW-1:0] pr;
    logic [RW-1:0] r2, b;

    if (k == 0) begin : g_first
      assign y_i = '0;
      assign r_i = '0;
      assign n_i = npad;
    end else begin : g_next
      assign y_i = y_r[k-1];
      assign r_i = r_r[k-1];
      assign n_i = n_r[k-1];
    end

    // trial digit: (2y+1)^3 - (2y)^3 = 3*2y*(2y+1) + 1
    always_comb begin
      y2  = {y_i[G-2:0], 1'b0};
      y2p = {1'b0, y2} + (G+1)'(1);
      pr  = PW'(y2) * PW'(y2p);
      r2  = {r_i[RW-4:0], n_i[NP-1 -: 3]};
      b   = RW'({pr, 1'b0}) + RW'(pr) + RW'(1);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= {n_i[NP-4:0], 3'b000};
        if (r2 >= b) begin
          r_r[k] <= r2 - b;
          y_r[k] <= {y2[G-1:1], 1'b1};
        end else begin
          r_r[k] <= r2;
          y_r[k] <= y2;
        end
      end
    end
  end

  assign root = y_r[G-1];

endmodule

// ----- rtl/pbe_recip.sv -----
// Pipelined rounded reciprocal 2^62/p30 by restoring division, one quotient bit per stage.
module pbe_recip import pbe_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  q32_t              p,
  output logic [RCP_QB-1:0] q
);

  logic [63:0]       d_r  [RCP_QB+1];
  logic [63:0]       rm_r [RCP_QB+1];
  logic [RCP_QB-1:0] lw_r [RCP_QB+1];
  logic [RCP_QB-1:0] q_r  [RCP_QB+1];

  logic [63:0] p30, dv;

  always_comb begin
    p30 = (64'(p) + 64'd2) >> 2;
    dv  = 64'h4000_0000_0000_0000 + (p30 >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]  <= p30;
      rm_r[0] <= dv >> RCP_QB;
      lw_r[0] <= dv[RCP_QB-1:0];
      q_r[0]  <= '0;
    end
  end

  for (genvar i = 1; i <= RCP_QB; i++) begin : g_div
    logic [63:0] t;
    assign t = {rm_r[i-1][62:0], lw_r[i-1][RCP_QB-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i]  <= d_r[i-1];
        lw_r[i] <= {lw_r[i-1][RCP_QB-2:0], 1'b0};
        if (t >= d_r[i-1]) begin
          rm_r[i] <= t - d_r[i-1];
          q_r[i]  <= {q_r[i-1][RCP_QB-2:0], 1'b1};
        end else begin
          rm_r[i] <= t;
          q_r[i]  <= {q_r[i-1][RCP_QB-2:0], 1'b0};
        end
      end
    end
  end

  assign q = q_r[RCP_QB];

endmodule

// ----- rtl/pbe_exchange_energy_potential.sv -----
// Top level: PBE exchange energy per electron and potential, fully pipelined.
//
// One grid point enters on in_if (density, grad_ratio, grad_curvature,
// laplacian_ratio) and one result leaves on out_if (energy_per_electron,
// potential, signed Q23.24 at the default fraction width, saturated).
// A request is taken when valid and ready are both high.
// Throughput: one point per cycle while the output is not stalled. The latency is
// set by the chain of eight dependent 5-stage multiplies around the 34-stage
// reciprocal divider (one quotient bit per stage).
// The cube root runs in parallel, one 3-bit radicand group per stage.
// All stages advance together. When the output register holds a result that
// the receiver does not take, the whole pipeline freezes and in_if.ready drops;
// nothing is dropped or repeated and the pending result stays stable.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not
// reset. Zero density gives zero on both result fields.
module pbe_exchange_energy_potential import pbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pbe_in_if.sink    in_if,
  pbe_out_if.source out_if
);

  localparam int M    = MUL_LAT;
  localparam int P    = 2 * M + RCP_LAT;
  localparam int LAST = P + 6 * M + 1;
  localparam int N_W  = 80 - FRAC_BITS;
  localparam int CB_G = (N_W + 2) / 3;
  localparam int OSH  = 32 - FRAC_BITS;
  localparam logic [64:0] OUT_RND = (65'd1 << OSH) >> 1;

  function automatic logic [OUT_W-1:0] to_out(input q32_t q);
    logic [63:0] ab;
    logic [64:0] mg;
    logic [64:0] mn;
    ab = q[63] ? 64'(-q) : 64'(q);
    mg = ({1'b0, ab} + OUT_RND) >> OSH;
    mn = -mg;
    if (!q[63] && mg > 65'h7FFF_FFFF_FFFF) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
    if (q[63] && mg > 65'h8000_0000_0000) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return q[63] ? mn[OUT_W-1:0] : mg[OUT_W-1:0];
  endfunction

  logic            en;
  logic [LAST:0]   vld_r;
  logic [31:0]     rho_r;
  q32_t            s_r, u_r, v_r;
  logic [OUT_W-1:0] ex_o_r, vx_o_r;

  assign en          = !vld_r[LAST] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rho_r <= in_if.density;
      s_r   <= q32_t'({24'd0, in_if.grad_ratio, 8'd0});
      u_r   <= q32_t'({{16{in_if.grad_curvature[31]}}, in_if.grad_curvature, 16'd0});
      v_r   <= q32_t'({{16{in_if.laplacian_ratio[31]}}, in_if.laplacian_ratio, 16'd0});
    end
  end

  // cube root of rho and the uniform-gas exchange term
  logic [CB_G-1:0] root;
  q32_t            r_q, exu, exu_a, exu_b;

  pbe_cbrt #(.N_W(N_W)) u_cbrt (
    .clk (clk), .en (en),
    .n   ({rho_r, {(48-FRAC_BITS){1'b0}}}),
    .root(root)
  );

  assign r_q = q32_t'({{(48-CB_G){1'b0}}, root, 16'd0});

  pbe_mulq u_m_exu (.clk(clk), .en(en), .a(AX_Q), .b(r_q), .y(exu));
  pbe_pipe #(.W(64), .DEPTH(P - CB_G)) u_d_exu_a (.clk(clk), .en(en), .d(exu), .q(exu_a));
  pbe_pipe #(.W(64), .DEPTH(4 * M)) u_d_exu_b (.clk(clk), .en(en), .d(exu_a), .q(exu_b));

  // gradient powers
  q32_t s2, t, s_d, s3, p1, w;

  pbe_mulq u_m_s2 (.clk(clk), .en(en), .a(s_r), .b(s_r), .y(s2));
  pbe_mulq u_m_t  (.clk(clk), .en(en), .a(UL_Q), .b(s_r), .y(t));
  pbe_pipe #(.W(64), .DEPTH(M)) u_d_s (.clk(clk), .en(en), .d(s_r), .q(s_d));
  pbe_mulq u_m_s3 (.clk(clk), .en(en), .a(s_d), .b(s2), .y(s3));
  pbe_mulq u_m_p1 (.clk(clk), .en(en), .a(UL_Q), .b(s2), .y(p1));
  pbe_mulq u_m_w  (.clk(clk), .en(en), .a(FOUR_THIRDS_Q), .b(s3), .y(w));

  // 1/p
  logic [RCP_QB-1:0] qip;
  q32_t              ip;

  pbe_recip u_recip (.clk(clk), .en(en), .p(ONE_Q + p1), .q(qip));
  assign ip = q32_t'({{(64-RCP_QB){1'b0}}, qip});

  // enhancement factor and its derivatives
  q32_t fxm, fx, ip2, fs, t_d, tf, v_d, vx3, ip_d, fss, u_d, w_d, vx4;
  q32_t vx2, vx2_d, vx3_d, ex, ex_d, vx;

  pbe_mulq u_m_fxm (.clk(clk), .en(en), .a(UK_Q), .b(ip), .y(fxm));
  pbe_mulq u_m_ip2 (.clk(clk), .en(en), .a(ip), .b(ip), .y(ip2));
  assign fx = ONE_Q + UK_Q - fxm;

  pbe_mulq u_m_fs  (.clk(clk), .en(en), .a(UM2_Q), .b(ip2), .y(fs));
  pbe_mulq u_m_vx2 (.clk(clk), .en(en), .a(FOUR_THIRDS_Q), .b(fx), .y(vx2));
  pbe_mulq u_m_ex  (.clk(clk), .en(en), .a(exu_a), .b(fx), .y(ex));

  pbe_pipe #(.W(64), .DEPTH(P + M)) u_d_t (.clk(clk), .en(en), .d(t), .q(t_d));
  pbe_pipe #(.W(64), .DEPTH(P + 2 * M)) u_d_v (.clk(clk), .en(en), .d(v_r), .q(v_d));
  pbe_mulq u_m_tf  (.clk(clk), .en(en), .a(t_d), .b(fs), .y(tf));
  pbe_mulq u_m_vx3 (.clk(clk), .en(en), .a(v_d), .b(fs), .y(vx3));

  pbe_pipe #(.W(64), .DEPTH(3 * M)) u_d_ip (.clk(clk), .en(en), .d(ip), .q(ip_d));
  pbe_mulq u_m_fss (.clk(clk), .en(en), .a(-(tf <<< 2)), .b(ip_d), .y(fss));

  pbe_pipe #(.W(64), .DEPTH(P + 4 * M)) u_d_u (.clk(clk), .en(en), .d(u_r), .q(u_d));
  pbe_pipe #(.W(64), .DEPTH(P + M)) u_d_w (.clk(clk), .en(en), .d(w), .q(w_d));
  pbe_mulq u_m_vx4 (.clk(clk), .en(en), .a(u_d - w_d), .b(fss), .y(vx4));

  pbe_pipe #(.W(64), .DEPTH(3 * M)) u_d_vx2 (.clk(clk), .en(en), .d(vx2), .q(vx2_d));
  pbe_pipe #(.W(64), .DEPTH(2 * M)) u_d_vx3 (.clk(clk), .en(en), .d(vx3), .q(vx3_d));
  pbe_mulq u_m_vx (.clk(clk), .en(en), .a(exu_b), .b(vx2_d - vx4 - vx3_d), .y(vx));

  pbe_pipe #(.W(64), .DEPTH(4 * M)) u_d_ex (.clk(clk), .en(en), .d(ex), .q(ex_d));

  always_ff @(posedge clk) begin
    if (en) begin
      ex_o_r <= to_out(ex_d);
      vx_o_r <= to_out(vx);
    end
  end

  assign out_if.valid               = vld_r[LAST];
  assign out_if.energy_per_electron = ex_o_r;
  assign out_if.potential           = vx_o_r;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !en) |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_ip_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P] |-> (ip > 0 && ip <= ONE_Q))
    else $error("reciprocal out of range");

  a_fx_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P + M] |-> (fx >= ONE_Q))
    else $error("enhancement factor below one");

  a_exu_sign: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CB_G + M] |-> (exu <= 0))
    else $error("uniform exchange term positive");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for the PBE exchange pipeline: streams grid points, checks energy and potential.
`timescale 1ns / 1ps

module tb import pbe_pkg::*; ();

  typedef struct packed {
    logic        [31:0] density;
    logic        [31:0] grad_ratio;
    logic signed [31:0] grad_curvature;
    logic signed [31:0] laplacian_ratio;
  } grid_point_t;

  typedef struct packed {
    logic signed [47:0] energy_per_electron;
    logic signed [47:0] potential;
  } exchange_t;

  localparam longint Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Q_MIN     = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
  localparam longint E_MAX     = (64'sd1 <<< 47) - 1;
  localparam longint E_MIN     = -(64'sd1 <<< 47);
  localparam int     STALL_MAX = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pbe_in_if  in_ch();
  pbe_out_if out_ch();

  pbe_exchange_energy_potential dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always #1 clk = ~clk;

  grid_point_t point_q[$];
  exchange_t   exchange_q[$];
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold = 0;
  int          sent = 0, checked = 0, errors = 0;
  int          quiet_cycles = 0;
  logic        in_taken = 1'b0;

  // Rounded, saturating fixed-point product (ties away from zero).
  function automatic longint qmul(longint a, longint b, int sh);
    logic         neg;
    logic [63:0]  ua, ub;
    logic [127:0] prod;
    neg  = (a < 0) != (b < 0);
    ua   = a < 0 ? -a : a;
    ub   = b < 0 ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = (prod + (128'd1 << (sh - 1))) >> sh;
    if (prod > 128'h7FFF_FFFF_FFFF_FFFF) return neg ? Q_MIN : Q_MAX;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic [63:0] cube_root(logic [63:0] n);
    int          bits;
    logic [63:0] x, nx;
    bits = 0;
    if (n == 0) return 0;
    for (int i = 0; i < 64; i++) if (n[i]) bits = i + 1;
    x = 64'd1 << ((bits + 2) / 3);
    for (int i = 0; i < 12; i++) begin
      nx = (2 * x + n / (x * x)) / 3;
      if (nx < x) x = nx;
    end
    return x;
  endfunction

  function automatic longint to_result(longint q);
    longint r;
    r = qmul(q, 64'sd1 <<< FRAC_BITS_DEF, 32);
    if (r > E_MAX) r = E_MAX;
    if (r < E_MIN) r = E_MIN;
    return r;
  endfunction

  function automatic exchange_t pbe_exchange(grid_point_t pt);
    longint      s, u, v, r, exunif, s2, s3, p0, ip, fx, ex, ip2, fs, t, fss;
    longint      vx2, vx3, vx4, vx, er, vr;
    logic [63:0] p30;
    exchange_t   res;
    s      = longint'({24'd0, pt.grad_ratio, 8'd0});
    u      = longint'(pt.grad_curvature) * 65536;
    v      = longint'(pt.laplacian_ratio) * 65536;
    r      = longint'(cube_root({32'd0, pt.density} << (48 - FRAC_BITS_DEF))) * 65536;
    exunif = qmul(AX_Q, r, 32);
    s2     = qmul(s, s, 32);
    s3     = qmul(s, s2, 32);
    p0     = ONE_Q + qmul(UL_Q, s2, 32);
    p30    = (p0 + 64'd2) >> 2;
    ip     = longint'(((64'd1 << 62) + p30 / 2) / p30);
    fx     = ONE_Q + UK_Q - qmul(UK_Q, ip, 32);
    ex     = qmul(exunif, fx, 32);
    ip2    = qmul(ip, ip, 32);
    fs     = qmul(UM2_Q, ip2, 32);
    t      = qmul(UL_Q, s, 32);
    fss    = qmul(-4 * qmul(t, fs, 32), ip, 32);
    vx2    = qmul(FOUR_THIRDS_Q, fx, 32);
    vx3    = qmul(v, fs, 32);
    vx4    = qmul(u - qmul(FOUR_THIRDS_Q, s3, 32), fss, 32);
    vx     = qmul(exunif, vx2 - vx4 - vx3, 32);
    er     = to_result(ex);
    vr     = to_result(vx);
    res.energy_per_electron = er[47:0];
    res.potential           = vr[47:0];
    return res;
  endfunction

  function automatic grid_point_t random_point();
    grid_point_t pt;
    if ($urandom_range(0, 9) < 7) begin
      // physical range: modest density, s up to a few units, small u and v
      pt.density         = $urandom_range(0, 32'h0FFF_FFFF) >> $urandom_range(0, 20);
      pt.grad_ratio      = $urandom_range(0, 32'h0400_0000);
      pt.grad_curvature  = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      pt.laplacian_ratio = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    end else begin
      pt = {$urandom, $urandom, $urandom, $urandom};
    end
    return pt;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (point_q.size() != 0 || exchange_q.size() != 0 || in_ch.valid);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (point_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        {in_ch.density, in_ch.grad_ratio, in_ch.grad_curvature,
         in_ch.laplacian_ratio} <= point_q.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random idling, plus a counted hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold      <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    exchange_t exp_res;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        exchange_q.push_back(pbe_exchange({in_ch.density, in_ch.grad_ratio,
                                           in_ch.grad_curvature, in_ch.laplacian_ratio}));
        sent <= sent + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exchange_q.size() == 0) begin
          $display("%0t: unexpected result energy=%h potential=%h", $time,
                   out_ch.energy_per_electron, out_ch.potential);
          errors = errors + 1;
        end else begin
          exp_res = exchange_q.pop_front();
          if (out_ch.energy_per_electron !== exp_res.energy_per_electron) begin
            $display("%0t: energy expected %h got %h", $time,
                     exp_res.energy_per_electron, out_ch.energy_per_electron);
            errors = errors + 1;
          end
          if (out_ch.potential !== exp_res.potential) begin
            $display("%0t: potential expected %h got %h", $time,
                     exp_res.potential, out_ch.potential);
            errors = errors + 1;
          end
          checked <= checked + 1;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("%0t: timeout, %0d results outstanding", $time, exchange_q.size());
        $display("pbe_exchange_energy_potential: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.density         = '0;
    in_ch.grad_ratio      = '0;
    in_ch.grad_curvature  = '0;
    in_ch.laplacian_ratio = '0;
    out_ch.ready          = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // corners: zero and full density, zero and full s, extreme u and v
    point_q.push_back('{32'd0, 32'd0, 32'sd0, 32'sd0});
    point_q.push_back('{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
    point_q.push_back('{32'd1, 32'd0, 32'sd0, 32'sd0});
    point_q.push_back('{32'h0100_0000, 32'd0, 32'sd0, 32'sd0});
    point_q.push_back('{32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 32'h0001_0000});
    point_q.push_back('{32'hFFFF_FFFF, 32'd0, 32'sd0, 32'sd0});
    point_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    point_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    point_q.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
    point_q.push_back('{32'h0000_0008, 32'h0800_0000, 32'hFFFF_FFFF, 32'h0000_0001});
    point_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000});
    point_q.push_back('{32'h0040_0000, 32'h0200_0000, 32'hFFF0_0000, 32'h0010_0000});
    point_q.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0001});
    point_q.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    point_q.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    drain();

    tx_idle_pct = 36;
    rx_idle_pct = 87;
    repeat (145) point_q.push_back(random_point());
    drain();

    // long receiver stall: pipeline fills and input backs up
    tx_idle_pct = 87;
    rx_idle_pct = 36;
    rx_hold     = 250;
    tx_idle_pct = 0;
    repeat (150) point_q.push_back(random_point());
    repeat (300) @(posedge clk);
    tx_idle_pct = 87;
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (150) point_q.push_back(random_point());
    drain();
    repeat (100) @(posedge clk);

    $display("Run covered %0d grid points (corners, physical and full-range random)", sent);
    $display("under sender/receiver idling and a long output stall; %0d results checked",
             checked);
    if (errors == 0 && exchange_q.size() == 0) begin
      $display("pbe_exchange_energy_potential: match");
    end else begin
      $display("pbe_exchange_energy_potential: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pbe_pkg.sv
rtl/pbe_if.sv
rtl/pbe_pipe.sv
rtl/pbe_mulq.sv
rtl/pbe_cbrt.sv
rtl/pbe_recip.sv
rtl/pbe_exchange_energy_potential.sv
tb/tb.sv
